FILE: src/white_patch_balance_defines.svh
// ----------------------------------------------------------------------------
// White patch balance assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef WHITE_PATCH_BALANCE_DEFINES_SVH
`define WHITE_PATCH_BALANCE_DEFINES_SVH

// same-cycle implication
`define WPB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("white_patch_balance: assertion failed");

// next-cycle implication
`define WPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("white_patch_balance: assertion failed");

`endif

FILE: src/wpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White patch balance package
// Payload types, command and register codes, and sizing constants.
// ----------------------------------------------------------------------------
package wpb_pkg;

  localparam int unsigned PixW         = 8;
  localparam int unsigned ProdW        = 2 * PixW;
  localparam int unsigned CfgIndexW    = 2;
  localparam int unsigned CfgDataW     = 8;
  localparam int unsigned DivSteps     = PixW;
  localparam int unsigned StepW        = $clog2(DivSteps);
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [PixW-1:0] PixMax   = {PixW{1'b1}};
  localparam logic [PixW-1:0] WhiteRst = {PixW{1'b1}};

  localparam logic CMD_GATHER = 1'b0;
  localparam logic CMD_APPLY  = 1'b1;

  localparam logic [CfgIndexW-1:0] CFG_WHITE_RED   = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_WHITE_GREEN = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_WHITE_BLUE  = 2'd2;

  typedef struct packed {
    logic            command;
    logic            first_pixel;
    logic [PixW-1:0] in_red;
    logic [PixW-1:0] in_green;
    logic [PixW-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] out_red;
    logic [PixW-1:0] out_green;
    logic [PixW-1:0] out_blue;
  } pix_out_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic [PixW-1:0] peak_red;
    logic [PixW-1:0] peak_green;
    logic [PixW-1:0] peak_blue;
    logic [PixW-1:0] white_red;
    logic [PixW-1:0] white_green;
    logic [PixW-1:0] white_blue;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_ctrl_t;

endpackage

FILE: src/wpb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White patch balance front end
// Holds target levels and channel peaks, folds gather pixels into the peaks
// and queues apply pixels with the peaks and targets they use.
// ----------------------------------------------------------------------------
module wpb_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  wpb_pkg::pix_in_t                  in_req_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wpb_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [wpb_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wpb_pkg::q_status_t                q_status_i,
  output logic                              q_push_o,
  output wpb_pkg::job_t                     q_job_o
);
  import wpb_pkg::*;

  logic [PixW-1:0] white_red_q, white_green_q, white_blue_q;
  logic [PixW-1:0] peak_red_q, peak_green_q, peak_blue_q;
  logic            accept;
  logic            cfg_write;

  assign in_stall_o  = q_status_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign q_push_o    = accept && (in_req_i.command == CMD_APPLY);

  always_comb begin
    q_job_o.red         = in_req_i.in_red;
    q_job_o.green       = in_req_i.in_green;
    q_job_o.blue        = in_req_i.in_blue;
    q_job_o.peak_red    = peak_red_q;
    q_job_o.peak_green  = peak_green_q;
    q_job_o.peak_blue   = peak_blue_q;
    q_job_o.white_red   = white_red_q;
    q_job_o.white_green = white_green_q;
    q_job_o.white_blue  = white_blue_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_red_q   <= WhiteRst;
      white_green_q <= WhiteRst;
      white_blue_q  <= WhiteRst;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_WHITE_RED:   white_red_q   <= cfg_data_i[PixW-1:0];
        CFG_WHITE_GREEN: white_green_q <= cfg_data_i[PixW-1:0];
        CFG_WHITE_BLUE:  white_blue_q  <= cfg_data_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_red_q   <= '0;
      peak_green_q <= '0;
      peak_blue_q  <= '0;
    end else if (accept && (in_req_i.command == CMD_GATHER)) begin
      if (in_req_i.first_pixel) begin
        peak_red_q   <= in_req_i.in_red;
        peak_green_q <= in_req_i.in_green;
        peak_blue_q  <= in_req_i.in_blue;
      end else begin
        if (in_req_i.in_red > peak_red_q)     peak_red_q   <= in_req_i.in_red;
        if (in_req_i.in_green > peak_green_q) peak_green_q <= in_req_i.in_green;
        if (in_req_i.in_blue > peak_blue_q)   peak_blue_q  <= in_req_i.in_blue;
      end
    end
  end

endmodule

FILE: src/wpb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White patch balance job queue
// Short FIFO of apply jobs between the front end and the divider back end.
// ----------------------------------------------------------------------------
module wpb_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wpb_pkg::job_t      push_job_i,
  input  logic               pop_i,
  output wpb_pkg::job_t      head_job_o,
  output wpb_pkg::q_status_t status_o
);
  import wpb_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_job_o     = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/wpb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White patch balance channel lane
// Multiplies a component by its target level, then divides by the peak one
// quotient bit per step, with saturation and zero-peak handling.
// ----------------------------------------------------------------------------
module wpb_lane (
  input  logic                      clk_i,
  input  wpb_pkg::lane_ctrl_t       ctrl_i,
  input  logic [wpb_pkg::PixW-1:0]  value_i,
  input  logic [wpb_pkg::PixW-1:0]  white_i,
  input  logic [wpb_pkg::PixW-1:0]  peak_i,
  output logic [wpb_pkg::PixW-1:0]  result_o
);
  import wpb_pkg::*;

  logic [ProdW-1:0] prod;
  logic [PixW:0]    trial;
  logic [PixW:0]    diff;
  logic             fits;
  logic [PixW-1:0]  rem_q, low_q, quo_q, peak_q;
  logic             zero_q, sat_q;

  always_comb begin
    prod  = {{PixW{1'b0}}, value_i} * {{PixW{1'b0}}, white_i};
    trial = {rem_q, low_q[PixW-1]};
    fits  = (trial >= {1'b0, peak_q});
    diff  = trial - {1'b0, peak_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q  <= prod[ProdW-1:PixW];
      low_q  <= prod[PixW-1:0];
      quo_q  <= '0;
      peak_q <= peak_i;
      zero_q <= (peak_i == '0);
      sat_q  <= (prod[ProdW-1:PixW] >= peak_i);
    end else if (ctrl_i.step) begin
      rem_q <= fits ? diff[PixW-1:0] : trial[PixW-1:0];
      low_q <= {low_q[PixW-2:0], 1'b0};
      quo_q <= {quo_q[PixW-2:0], fits};
    end
  end

  assign result_o = zero_q ? '0 : (sat_q ? PixMax : quo_q);

endmodule

FILE: src/wpb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White patch balance back end
// Takes queued apply jobs, runs the three channel lanes through the division
// and holds the corrected pixel in the output register.
// ----------------------------------------------------------------------------
module wpb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpb_pkg::q_status_t q_status_i,
  input  wpb_pkg::job_t      q_job_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wpb_pkg::pix_out_t  out_rsp_o
);
  import wpb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q;
  logic [StepW-1:0] step_cnt_q;
  lane_ctrl_t       lane_ctrl;
  logic             load_out;
  logic             out_valid_q;
  pix_out_t         out_q;
  pix_out_t         lane_res;

  always_comb begin
    q_pop_o         = (state_q == ST_IDLE) && !q_status_i.empty;
    lane_ctrl.start = q_pop_o;
    lane_ctrl.step  = (state_q == ST_DIV);
    load_out        = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  wpb_lane u_lane_red (
    .clk_i   (clk_i),
    .ctrl_i  (lane_ctrl),
    .value_i (q_job_i.red),
    .white_i (q_job_i.white_red),
    .peak_i  (q_job_i.peak_red),
    .result_o(lane_res.out_red)
  );

  wpb_lane u_lane_green (
    .clk_i   (clk_i),
    .ctrl_i  (lane_ctrl),
    .value_i (q_job_i.green),
    .white_i (q_job_i.white_green),
    .peak_i  (q_job_i.peak_green),
    .result_o(lane_res.out_green)
  );

  wpb_lane u_lane_blue (
    .clk_i   (clk_i),
    .ctrl_i  (lane_ctrl),
    .value_i (q_job_i.blue),
    .white_i (q_job_i.white_blue),
    .peak_i  (q_job_i.peak_blue),
    .result_o(lane_res.out_blue)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            state_q    <= ST_DIV;
            step_cnt_q <= '0;
          end
        end
        ST_DIV: begin
          step_cnt_q <= step_cnt_q + 1'b1;
          if (step_cnt_q == StepW'(DivSteps - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= lane_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: src/white_patch_balance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White patch balance top level
// Max-RGB white balance: gather requests track channel peaks, apply requests
// scale each channel by target level over peak, saturated to full scale.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    in_req_i   (pix_in_t)
//  out      output     out_valid_o / out_stall_i  out_rsp_o  (pix_out_t)
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  A gather request updates the peaks in the front end and yields no result.
//  An apply request: the back end registers the product as it takes the job,
//  runs eight restoring division steps in the channel lanes, then loads the
//  output register; the shared divider loop sets the apply rate.
//  Reset clears the peaks to zero and the target levels to full scale.
//  in_stall_o rises only while the job queue is full; out_stall_i holds the
//  result register and, once the back end finishes, the next job.
// ----------------------------------------------------------------------------
`include "white_patch_balance_defines.svh"

module white_patch_balance #(
  parameter int unsigned QueueDepth = wpb_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wpb_pkg::pix_in_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wpb_pkg::pix_out_t             out_rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wpb_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [wpb_pkg::CfgDataW-1:0]  cfg_data_i
);
  import wpb_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  job_t      push_job;
  job_t      head_job;
  logic      gather_accept;

  assign gather_accept = in_valid_i && !in_stall_o && (in_req_i.command == CMD_GATHER);

  wpb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  wpb_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_job_i(push_job),
    .pop_i     (q_pop),
    .head_job_o(head_job),
    .status_o  (q_status)
  );

  wpb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  `WPB_ASSERT_NOW(a_gather_not_queued, gather_accept, !q_push)
  `WPB_ASSERT_NEXT(a_push_fills_queue, q_push, !q_status.empty)
  `WPB_ASSERT_NOW(a_pop_has_job, q_pop, !q_status.empty)

endmodule
